### sv/brbw_pkg.sv
// Shared types and constants of the base relocation block walker.
package brbw_pkg;

    // Header length of a relocation block in bytes
    localparam logic [31:0] HeaderBytes = 32'd8;
    // Entry offset width and the type field position
    localparam int OffsetBits = 12;

    // Reset value of the entry limit register
    localparam logic [31:0] EntryLimitReset = 32'd65536;

    // Depth of the result queue and its pointer width
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // Result event codes
    typedef enum logic [2:0] {
        EV_ENTRY  = 3'd0,
        EV_NORMAL = 3'd1,
        EV_ZERO   = 3'd2,
        EV_PAST   = 3'd3,
        EV_SHORT  = 3'd4,
        EV_LIMIT  = 3'd5
    } t_event;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_DIRECTORY_LENGTH = 1'b0,
        REG_ENTRY_LIMIT      = 1'b1
    } t_reg_index;

    // Configuration register values
    typedef struct packed {
        logic [31:0] directory_length;
        logic [31:0] entry_limit;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [31:0] target_rva;
        logic [3:0]  reloc_type;
        t_event      event_res;
        logic        last;
    } t_result;

    // Results produced by one accepted byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

endpackage

### sv/base_relocation_block_walker_top.sv
// Top level of the base relocation block walker.
//
// Input channel: one relocation directory byte per item (i_data_byte), with
// i_first_byte marking byte 0 of a new directory. An item is taken at a clock
// edge with i_valid high and o_stall low.
// Output channel: result items (o_target_rva, o_reloc_type, o_event_res,
// o_last), taken at an edge with o_valid high and i_stall low. Entries give
// event 0; the one terminating item of a walk has o_last set.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 directory length, 1 entry limit) at the clock edge; write only when idle.
// Throughput: one byte per cycle while o_stall is low. Each byte is walked
// combinationally; its results (at most two) enter a four-item result queue
// at the edge taking the byte, leaving at one per cycle while i_stall is low.
// o_stall rises while the queue holds three or more items, i.e. when the
// receiver holds i_stall for long enough; it falls as the queue drains.
// Reset (i_rst_n low, synchronous) empties the queue, restarts the walk and
// sets the directory length to 0 and the entry limit to 65536.
module base_relocation_block_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_target_rva,
    output logic [3:0]  o_reloc_type,
    output logic [2:0]  o_event_res,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    brbw_pkg::t_cfg    r_cfg;
    brbw_pkg::t_step   step;
    brbw_pkg::t_result head;
    logic              accept;
    logic              full;

    assign accept = i_valid && !full;
    assign o_stall = full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.directory_length <= '0;
            r_cfg.entry_limit      <= brbw_pkg::EntryLimitReset;
        end else if (i_cfg_we) begin
            unique case (brbw_pkg::t_reg_index'(i_cfg_index))
                brbw_pkg::REG_DIRECTORY_LENGTH: r_cfg.directory_length <= i_cfg_data;
                brbw_pkg::REG_ENTRY_LIMIT:      r_cfg.entry_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    brbw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_cfg        (r_cfg),
        .o_step       (step)
    );

    brbw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_push_en (accept),
        .i_pop     (!i_stall),
        .o_full    (full),
        .o_valid   (o_valid),
        .o_head    (head)
    );

    // Result item fields
    assign o_target_rva = head.target_rva;
    assign o_reloc_type = head.reloc_type;
    assign o_event_res  = head.event_res;
    assign o_last       = head.last;

endmodule

### sv/brbw_walker.sv
// Walker state and result generation for one accepted directory byte per cycle.
module brbw_walker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_byte,
    input  brbw_pkg::t_cfg  i_cfg,
    output brbw_pkg::t_step o_step
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2
    } t_phase;

    // True when fewer than a header's worth of bytes remain from the given offset
    function automatic logic few_left(input logic [31:0] from, input logic [31:0] len);
        logic [31:0] diff;
        diff = len - from;
        return (from >= len) || (diff < brbw_pkg::HeaderBytes);
    endfunction

    logic [31:0] r_pos, n_pos;
    logic [31:0] r_bs, n_bs;
    logic [32:0] r_be, n_be;
    logic [31:0] r_pa, n_pa;
    logic [31:0] r_sz, n_sz;
    logic [7:0]  r_elb, n_elb;
    logic [31:0] r_cnt, n_cnt;
    t_phase      r_phase, n_phase;
    logic        r_stop, n_stop;

    // State as seen by this byte: a first byte restarts the walk
    logic [31:0] e_pos, e_bs, e_pa, e_sz, e_cnt;
    logic [32:0] e_be;
    t_phase      e_phase;
    logic        e_stop;

    logic [31:0] off, room, pa_base, sz_base, ins;
    logic [32:0] pos_next, new_be;
    logic        at_end;
    brbw_pkg::t_result end_res, entry_res;

    always_comb begin
        e_pos   = i_first_byte ? '0 : r_pos;
        e_bs    = i_first_byte ? '0 : r_bs;
        e_be    = i_first_byte ? '0 : r_be;
        e_pa    = i_first_byte ? '0 : r_pa;
        e_sz    = i_first_byte ? '0 : r_sz;
        e_cnt   = i_first_byte ? '0 : r_cnt;
        e_phase = i_first_byte ? PH_HEADER : r_phase;
        e_stop  = i_first_byte ? 1'b0 : r_stop;
    end

    // Header byte assembly and the running compares
    always_comb begin
        off      = e_pos - e_bs;
        room     = (e_bs >= i_cfg.directory_length) ? '0 : (i_cfg.directory_length - e_bs);
        pa_base  = (off == '0) ? '0 : e_pa;
        sz_base  = (off == '0) ? '0 : e_sz;
        ins      = {24'd0, i_data_byte} << {off[1:0], 3'b000};
        pos_next = {1'b0, e_pos} + 33'd1;
        at_end   = (pos_next == e_be);
        new_be   = {1'b0, e_bs} + {1'b0, sz_base | ((off < 32'd4) ? '0 : ins)};
    end

    // Result templates
    always_comb begin
        end_res            = '0;
        end_res.last       = 1'b1;
        entry_res.target_rva = e_pa + {{(32 - brbw_pkg::OffsetBits){1'b0}},
                                       i_data_byte[3:0], r_elb};
        entry_res.reloc_type = i_data_byte[7:4];
        entry_res.event_res  = brbw_pkg::EV_ENTRY;
        entry_res.last       = 1'b0;
    end

    // Next state and results
    always_comb begin
        n_pos   = e_pos;
        n_bs    = e_bs;
        n_be    = e_be;
        n_pa    = e_pa;
        n_sz    = e_sz;
        n_elb   = r_elb;
        n_cnt   = e_cnt;
        n_phase = e_phase;
        n_stop  = e_stop;
        o_step  = '0;
        o_step.r0 = end_res;
        o_step.r1 = end_res;
        o_step.r1.event_res = brbw_pkg::EV_NORMAL;
        if (!e_stop) begin
            n_pos = pos_next[31:0];
            unique case (e_phase)
                PH_HEADER: begin
                    if (off == '0 && few_left(e_pos, i_cfg.directory_length)) begin
                        n_stop = 1'b1;
                        o_step.count = 2'd1;
                        o_step.r0.event_res = brbw_pkg::EV_NORMAL;
                    end else begin
                        n_pa = (off < 32'd4) ? (pa_base | ins) : pa_base;
                        n_sz = (off < 32'd4) ? sz_base : (sz_base | ins);
                        if (off >= 32'd7) begin
                            if (n_sz == '0) begin
                                n_stop = 1'b1;
                                o_step.count = 2'd1;
                                o_step.r0.event_res = brbw_pkg::EV_ZERO;
                            end else if (n_sz > room) begin
                                n_stop = 1'b1;
                                o_step.count = 2'd1;
                                o_step.r0.event_res = brbw_pkg::EV_PAST;
                            end else if (n_sz < brbw_pkg::HeaderBytes) begin
                                n_stop = 1'b1;
                                o_step.count = 2'd1;
                                o_step.r0.event_res = brbw_pkg::EV_SHORT;
                            end else begin
                                n_be = new_be;
                                if (n_sz == brbw_pkg::HeaderBytes) begin
                                    // Empty block: straight on to the next header
                                    n_bs    = new_be[31:0];
                                    n_phase = PH_HEADER;
                                    if (few_left(new_be[31:0], i_cfg.directory_length)) begin
                                        n_stop = 1'b1;
                                        o_step.count = 2'd1;
                                        o_step.r0.event_res = brbw_pkg::EV_NORMAL;
                                    end
                                end else begin
                                    n_phase = PH_LOW;
                                end
                            end
                        end
                    end
                end
                PH_LOW: begin
                    if (at_end) begin
                        // Odd trailing byte closes the block
                        n_bs    = e_be[31:0];
                        n_phase = PH_HEADER;
                        if (few_left(e_be[31:0], i_cfg.directory_length)) begin
                            n_stop = 1'b1;
                            o_step.count = 2'd1;
                            o_step.r0.event_res = brbw_pkg::EV_NORMAL;
                        end
                    end else begin
                        n_elb   = i_data_byte;
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (e_cnt >= i_cfg.entry_limit) begin
                        n_stop = 1'b1;
                        o_step.count = 2'd1;
                        o_step.r0.event_res = brbw_pkg::EV_LIMIT;
                    end else begin
                        o_step.count = 2'd1;
                        o_step.r0    = entry_res;
                        n_cnt        = e_cnt + 32'd1;
                        if (at_end) begin
                            n_bs    = e_be[31:0];
                            n_phase = PH_HEADER;
                            if (few_left(e_be[31:0], i_cfg.directory_length)) begin
                                n_stop = 1'b1;
                                o_step.count = 2'd2;
                            end
                        end else begin
                            n_phase = PH_LOW;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_bs    <= '0;
            r_be    <= '0;
            r_pa    <= '0;
            r_sz    <= '0;
            r_elb   <= '0;
            r_cnt   <= '0;
            r_phase <= PH_HEADER;
            r_stop  <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_bs    <= n_bs;
            r_be    <= n_be;
            r_pa    <= n_pa;
            r_sz    <= n_sz;
            r_elb   <= n_elb;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_stop  <= n_stop;
        end
    end

`ifndef SYNTH
    // A stopped walk stays silent until a new directory starts
    a_silent_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop && !i_first_byte) |-> (o_step.count == 2'd0))
        else $error("walker produced a result after the walk ended");

    // Two results only as an entry followed by the normal end
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_step.count == 2'd2) |-> (o_step.r0.event_res == brbw_pkg::EV_ENTRY
            && o_step.r1.event_res == brbw_pkg::EV_NORMAL && o_step.r1.last
            && !o_step.r0.last))
        else $error("walker produced a malformed result pair");
`endif

endmodule

### sv/brbw_queue.sv
// Result queue taking up to two items a cycle and delivering one while popped.
module brbw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brbw_pkg::t_step   i_step,
    input  logic              i_push_en,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output brbw_pkg::t_result o_head
);

    brbw_pkg::t_result r_mem [brbw_pkg::QueueDepth];
    logic [brbw_pkg::QueuePtrW-1:0] r_wr, r_rd, wr_next;
    logic [brbw_pkg::QueuePtrW:0]   r_count, n_count;
    logic [1:0]                     push;
    logic                           pop;

    // Occupancy bookkeeping
    always_comb begin
        push    = i_push_en ? i_step.count : 2'd0;
        pop     = i_pop && o_valid;
        wr_next = r_wr + {{(brbw_pkg::QueuePtrW - 1){1'b0}}, 1'b1};
        n_count = r_count + {{(brbw_pkg::QueuePtrW - 1){1'b0}}, push}
                  - {{brbw_pkg::QueuePtrW{1'b0}}, pop};
        o_valid = (r_count != '0);
        // No room for a possible pair of results
        o_full  = (r_count > (brbw_pkg::QueuePtrW + 1)'(brbw_pkg::QueueDepth - 2));
        o_head  = r_mem[r_rd];
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push[brbw_pkg::QueuePtrW-1:0];
            r_rd    <= r_rd + {{(brbw_pkg::QueuePtrW - 1){1'b0}}, pop};
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_mem[r_wr] <= i_step.r0;
        end
        if (push == 2'd2) begin
            r_mem[wr_next] <= i_step.r1;
        end
    end

`ifndef SYNTH
    // Occupancy never exceeds the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (brbw_pkg::QueuePtrW + 1)'(brbw_pkg::QueueDepth))
        else $error("result queue overflow");

    // Items are written only when room for a pair was shown
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push != 2'd0) |-> !o_full)
        else $error("result queue written while full");
`endif

endmodule
